// ===== hw/rtl/tidfa_pkg.sv =====
// Shared widths, codes and control types of the typed id free-list allocator.
package tidfa_pkg;

  localparam int unsigned CMD_W    = 1;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned REL_W    = 9;
  localparam int unsigned GIVEN_W  = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED    = 3'd0,
    ST_FRESH     = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic cls_rd;
    logic id_rd;
    logic commit;
    logic clr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic rel_ok;
    logic cls_nonempty;
    logic id_in_use;
    logic clr_last;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== hw/rtl/tidfa_req_if.sv =====
// Request channel: command, class key and id to release.
interface tidfa_req_if import tidfa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [KEY_W-1:0]        class_key;
  logic signed [REL_W-1:0] release_id;

  modport source (output valid, output cmd, output class_key, output release_id, input ready);
  modport sink   (input valid, input cmd, input class_key, input release_id, output ready);
endinterface

// ===== hw/rtl/tidfa_rsp_if.sv =====
// Response channel: id handed out and request status.
interface tidfa_rsp_if import tidfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GIVEN_W-1:0]  given_id;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output given_id, output status, input ready);
  modport sink   (input valid, input given_id, input status, output ready);
endinterface

// ===== hw/rtl/typed_id_free_list_allocator.sv =====
// Top level of the typed id free-list allocator.
// Requests arrive on req_i: cmd allocate takes an id for class_key, cmd release
// returns release_id to the free stack of the class it was allocated under.
// Each request gives one transfer on rsp_o with given_id and status.
// An allocate reuses the most recently released id of its class, or else a
// fresh id from a rising counter; with neither left it reports exhausted.
// A release of a negative, out-of-range or idle id is reported and dropped.
// A request passes the look, chase and done states; the response is registered
// at commit. No new request is taken until then, due to the two dependent reads of
// the single-port class-head and id-link memories ahead of the write-back.
// After reset the block clears both memories, one entry a cycle, over
// max(MAX_IDS, KEY_CLASSES) entries, with req_i.ready low, then takes requests.
// The response register holds its transfer while rsp_o.ready is low; a new
// request is taken meanwhile and waits before commit until the slot frees.
module typed_id_free_list_allocator import tidfa_pkg::*; #(
  parameter int unsigned MAX_IDS     = 256,
  parameter int unsigned KEY_CLASSES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tidfa_req_if.sink   req_i,
  tidfa_rsp_if.source rsp_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  tidfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  tidfa_datapath #(
    .MAX_IDS     (MAX_IDS),
    .KEY_CLASSES (KEY_CLASSES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .req_cmd_i    (req_i.cmd),
    .class_key_i  (req_i.class_key),
    .release_id_i (req_i.release_id),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .given_id_o   (rsp_o.given_id),
    .status_o     (rsp_o.status)
  );

  assign req_i.ready = in_ready;

endmodule

// ===== hw/rtl/tidfa_datapath.sv =====
// Datapath: request registers, class and id memories, fresh counter, result register.
module tidfa_datapath import tidfa_pkg::*; #(
  parameter int unsigned MAX_IDS     = 256,
  parameter int unsigned KEY_CLASSES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic [CMD_W-1:0]        req_cmd_i,
  input  logic [KEY_W-1:0]        class_key_i,
  input  logic signed [REL_W-1:0] release_id_i,
  input  logic                    rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic [GIVEN_W-1:0]      given_id_o,
  output logic [STATUS_W-1:0]     status_o
);

  localparam int unsigned ID_W    = $clog2(MAX_IDS);
  localparam int unsigned CLS_W   = (KEY_CLASSES > 1) ? $clog2(KEY_CLASSES) : 1;
  localparam int unsigned CLR_N   = (MAX_IDS > KEY_CLASSES) ? MAX_IDS : KEY_CLASSES;
  localparam int unsigned CLR_W   = $clog2(CLR_N);
  localparam int unsigned FRESH_W = ID_W + 1;

  typedef struct packed {
    logic             in_use;
    logic [CLS_W-1:0] owner;
    logic             bottom;
    logic [ID_W-1:0]  link;
  } id_ent_t;

  typedef struct packed {
    logic            nonempty;
    logic [ID_W-1:0] head;
  } cls_ent_t;

  id_ent_t  id_mem  [MAX_IDS];
  cls_ent_t cls_mem [KEY_CLASSES];

  logic [CMD_W-1:0]        cmd_q;
  logic [CLS_W-1:0]        cls_q;
  logic signed [REL_W-1:0] rel_q;
  logic [FRESH_W-1:0]      fresh_q;
  logic [CLR_W-1:0]        clr_q;
  id_ent_t                 id_rd_q;
  cls_ent_t                cls_rd_q;
  logic                    out_valid_q;
  logic [GIVEN_W-1:0]      given_q;
  status_e                 status_q;

  logic [CLS_W-1:0] key_cls;
  logic             rel_ok;
  logic [ID_W-1:0]  rel_idx;
  logic [ID_W-1:0]  id_raddr;
  logic [CLS_W-1:0] cls_raddr;

  logic               id_we;
  logic [ID_W-1:0]    id_waddr;
  id_ent_t            id_wdata;
  logic               cls_we;
  logic [CLS_W-1:0]   cls_waddr;
  cls_ent_t           cls_wdata;
  logic               fresh_inc;
  logic [GIVEN_W-1:0] res_given;
  status_e            res_status;

  always_comb begin
    key_cls = '0;
    for (int i = 0; i < (1 << KEY_W); i++) begin
      if (class_key_i == KEY_W'(i)) begin
        key_cls = CLS_W'(i % KEY_CLASSES);
      end
    end
  end

  assign rel_ok  = !rel_q[REL_W-1] && (32'(rel_q[REL_W-2:0]) < MAX_IDS);
  assign rel_idx = ID_W'(rel_q[REL_W-2:0]);

  assign id_raddr  = (cmd_q == CMD_RELEASE) ? rel_idx : cls_rd_q.head;
  assign cls_raddr = (cmd_q == CMD_RELEASE) ? id_rd_q.owner : cls_q;

  always_comb begin
    id_we      = 1'b0;
    id_waddr   = '0;
    id_wdata   = '0;
    cls_we     = 1'b0;
    cls_waddr  = '0;
    cls_wdata  = '0;
    fresh_inc  = 1'b0;
    res_given  = '0;
    res_status = ST_IGNORED;
    if (cmd_q == CMD_ALLOC) begin
      if (cls_rd_q.nonempty) begin
        id_we              = 1'b1;
        id_waddr           = cls_rd_q.head;
        id_wdata.in_use    = 1'b1;
        id_wdata.owner     = cls_q;
        id_wdata.bottom    = id_rd_q.bottom;
        id_wdata.link      = id_rd_q.link;
        cls_we             = 1'b1;
        cls_waddr          = cls_q;
        cls_wdata.nonempty = !id_rd_q.bottom;
        cls_wdata.head     = id_rd_q.bottom ? cls_rd_q.head : id_rd_q.link;
        res_given          = GIVEN_W'(cls_rd_q.head);
        res_status         = ST_REUSED;
      end else if (fresh_q < FRESH_W'(MAX_IDS)) begin
        id_we           = 1'b1;
        id_waddr        = fresh_q[ID_W-1:0];
        id_wdata.in_use = 1'b1;
        id_wdata.owner  = cls_q;
        id_wdata.bottom = 1'b1;
        fresh_inc       = 1'b1;
        res_given       = GIVEN_W'(fresh_q[ID_W-1:0]);
        res_status      = ST_FRESH;
      end else begin
        res_status = ST_EXHAUSTED;
      end
    end else if (rel_ok && id_rd_q.in_use) begin
      id_we              = 1'b1;
      id_waddr           = rel_idx;
      id_wdata.in_use    = 1'b0;
      id_wdata.owner     = id_rd_q.owner;
      id_wdata.bottom    = !cls_rd_q.nonempty;
      id_wdata.link      = cls_rd_q.head;
      cls_we             = 1'b1;
      cls_waddr          = id_rd_q.owner;
      cls_wdata.nonempty = 1'b1;
      cls_wdata.head     = rel_idx;
      res_status         = ST_RELEASED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      if (32'(clr_q) < MAX_IDS) begin
        id_mem[clr_q[ID_W-1:0]] <= '0;
      end
    end else if (cmd_i.commit && id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
    if (cmd_i.id_rd) begin
      id_rd_q <= id_mem[id_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      if (32'(clr_q) < KEY_CLASSES) begin
        cls_mem[clr_q[CLS_W-1:0]] <= '0;
      end
    end else if (cmd_i.commit && cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
    if (cmd_i.cls_rd) begin
      cls_rd_q <= cls_mem[cls_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= req_cmd_i;
      cls_q <= key_cls;
      rel_q <= release_id_i;
    end
    if (cmd_i.commit) begin
      given_q  <= res_given;
      status_q <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + CLR_W'(1);
      end
      if (cmd_i.commit && fresh_inc) begin
        fresh_q <= fresh_q + FRESH_W'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.is_release   = (cmd_q == CMD_RELEASE);
  assign stat_o.rel_ok       = rel_ok;
  assign stat_o.cls_nonempty = cls_rd_q.nonempty;
  assign stat_o.id_in_use    = id_rd_q.in_use;
  assign stat_o.clr_last     = (clr_q == CLR_W'(CLR_N - 1));
  assign stat_o.out_full     = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign given_id_o  = given_q;
  assign status_o    = status_q;

endmodule

// ===== hw/rtl/tidfa_ctrl.sv =====
// Controller: sequences memory clearing, lookups and the commit of each request.
module tidfa_ctrl import tidfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_CHASE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat_i.is_release) begin
          cmd_o.id_rd = stat_i.rel_ok;
        end else begin
          cmd_o.cls_rd = 1'b1;
        end
        state_d = S_CHASE;
      end
      S_CHASE: begin
        if (stat_i.is_release) begin
          cmd_o.cls_rd = stat_i.rel_ok && stat_i.id_in_use;
        end else begin
          cmd_o.id_rd = stat_i.cls_nonempty;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_full) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the typed id free-list allocator: queued stimulus, in-order response check.
module tb;
  import tidfa_pkg::*;

  localparam int NUM_IDS     = 256;
  localparam int NUM_CLASSES = 16;
  localparam int ITEM_TARGET = 1720;
  localparam int CALM_FROM   = 1480;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] class_key;
    logic [REL_W-1:0] release_id;
  } alloc_req_t;

  typedef struct packed {
    logic [GIVEN_W-1:0] given_id;
    status_e            status;
  } alloc_rsp_t;

  logic clk_i;
  logic rst_ni;

  tidfa_req_if req_ch ();
  tidfa_rsp_if rsp_ch ();

  typed_id_free_list_allocator #(
    .MAX_IDS    (NUM_IDS),
    .KEY_CLASSES(NUM_CLASSES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  alloc_req_t req_pending[$];
  alloc_rsp_t grant_q[$];

  logic [8:0]         fresh_ctr;
  logic [GIVEN_W-1:0] cls_head     [NUM_CLASSES];
  logic               cls_nonempty [NUM_CLASSES];
  logic [8:0]         id_link      [NUM_IDS];
  logic [KEY_W-1:0]   id_owner     [NUM_IDS];
  logic               id_busy      [NUM_IDS];

  int   errors;
  int   sent;
  logic req_took;
  int   req_gap;
  int   rsp_gap;
  logic calm;
  logic idle_on;

  int   n_batch;
  int   mode;
  int   pick;
  int   idx;
  logic [KEY_W-1:0]   hot;
  logic [GIVEN_W-1:0] busy_ids[$];

  always #4 clk_i = ~clk_i;

  function automatic alloc_rsp_t predict_grant(alloc_req_t r);
    alloc_rsp_t       e;
    logic [KEY_W-1:0] c;
    logic [7:0]       id;
    e.given_id = '0;
    e.status   = ST_IGNORED;
    if (r.cmd == CMD_ALLOC) begin
      c = r.class_key;
      if (cls_nonempty[c]) begin
        id = cls_head[c];
        if (id_link[id] >= NUM_IDS) begin
          cls_nonempty[c] = 1'b0;
        end else begin
          cls_head[c] = id_link[id][7:0];
        end
        id_busy[id]  = 1'b1;
        id_owner[id] = c;
        e.given_id   = id;
        e.status     = ST_REUSED;
      end else if (fresh_ctr < NUM_IDS) begin
        id           = fresh_ctr[7:0];
        fresh_ctr    = fresh_ctr + 9'd1;
        id_busy[id]  = 1'b1;
        id_owner[id] = c;
        e.given_id   = id;
        e.status     = ST_FRESH;
      end else begin
        e.status = ST_EXHAUSTED;
      end
    end else if (!r.release_id[REL_W-1] && id_busy[r.release_id[7:0]]) begin
      id              = r.release_id[7:0];
      c               = id_owner[id];
      id_busy[id]     = 1'b0;
      id_link[id]     = cls_nonempty[c] ? {1'b0, cls_head[c]} : 9'(NUM_IDS);
      cls_head[c]     = id;
      cls_nonempty[c] = 1'b1;
      e.status        = ST_RELEASED;
    end
    return e;
  endfunction

  task automatic push_req(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                          input logic [REL_W-1:0] rl);
    alloc_req_t it;
    it.cmd        = c;
    it.class_key  = k;
    it.release_id = rl;
    req_pending.push_back(it);
    sent++;
  endtask

  task automatic wait_drained();
    while (req_pending.size() != 0 || grant_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_release();
    int r;
    r = $urandom_range(0, 19);
    if (busy_ids.size() != 0 && r < 16) begin
      idx = $urandom_range(0, busy_ids.size() - 1);
      push_req(CMD_RELEASE, KEY_W'($urandom), {1'b0, busy_ids[idx]});
      busy_ids.delete(idx);
    end else if (r < 18) begin
      push_req(CMD_RELEASE, KEY_W'($urandom), REL_W'($urandom_range(0, 255)));
    end else begin
      push_req(CMD_RELEASE, KEY_W'($urandom), {1'b1, 8'($urandom)});
    end
  endtask

  task automatic push_alloc();
    if ($urandom_range(0, 1) == 0) begin
      push_req(CMD_ALLOC, hot, REL_W'($urandom));
    end else begin
      push_req(CMD_ALLOC, KEY_W'($urandom), REL_W'($urandom));
    end
  endtask

  // drive requests
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && !req_took) begin
      end else if (req_gap != 0) begin
        req_ch.valid <= 1'b0;
        req_gap      <= req_gap - 1;
      end else if (!calm && idle_on && req_pending.size() != 0 &&
                   $urandom_range(0, 7) == 0) begin
        req_ch.valid <= 1'b0;
        req_gap      <= $urandom_range(0, 5);
      end else if (req_pending.size() != 0) begin
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= req_pending[0].cmd;
        req_ch.class_key  <= req_pending[0].class_key;
        req_ch.release_id <= req_pending[0].release_id;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // stall responses
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_gap != 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_gap      <= rsp_gap - 1;
      end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_gap      <= $urandom_range(0, 5);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // predict on request transfer, check on response transfer
  always @(posedge clk_i) begin
    alloc_req_t seen;
    alloc_rsp_t want;
    if (rst_ni) begin
      req_took <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        seen.cmd        = req_ch.cmd;
        seen.class_key  = req_ch.class_key;
        seen.release_id = req_ch.release_id;
        grant_q.push_back(predict_grant(seen));
        req_pending.pop_front();
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected response: given_id %0d, status %0d",
                 rsp_ch.given_id, rsp_ch.status);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (rsp_ch.given_id !== want.given_id) begin
            $error("given_id: expected %0d, actual %0d", want.given_id, rsp_ch.given_id);
            errors++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_ALLOC;
    req_ch.class_key  = '0;
    req_ch.release_id = '0;
    rsp_ch.ready      = 1'b0;
    errors            = 0;
    sent              = 0;
    req_took          = 1'b0;
    req_gap           = 0;
    rsp_gap           = 0;
    calm              = 1'b0;
    idle_on           = 1'b1;
    fresh_ctr         = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cls_head[i]     = '0;
      cls_nonempty[i] = 1'b0;
    end
    for (int i = 0; i < NUM_IDS; i++) begin
      id_link[i]  = '0;
      id_owner[i] = '0;
      id_busy[i]  = 1'b0;
    end

    push_req(CMD_ALLOC, 4'd0, 9'h1FF);
    push_req(CMD_ALLOC, 4'd15, 9'h000);
    push_req(CMD_ALLOC, 4'd0, 9'h0FF);
    push_req(CMD_RELEASE, 4'hF, 9'd0);
    push_req(CMD_RELEASE, 4'h0, 9'd2);
    push_req(CMD_ALLOC, 4'd0, 9'h100);
    push_req(CMD_ALLOC, 4'd0, 9'h0AA);
    push_req(CMD_ALLOC, 4'd0, 9'h155);
    push_req(CMD_RELEASE, 4'h5, 9'd2);
    push_req(CMD_RELEASE, 4'hA, 9'd2);
    push_req(CMD_RELEASE, 4'h0, 9'h1FF);
    push_req(CMD_RELEASE, 4'hF, 9'h100);
    push_req(CMD_RELEASE, 4'h3, 9'd255);
    push_req(CMD_RELEASE, 4'h0, 9'd1);
    push_req(CMD_ALLOC, 4'd7, 9'h000);
    push_req(CMD_ALLOC, 4'd15, 9'h1FF);
    push_req(CMD_RELEASE, 4'h9, 9'd1);
    push_req(CMD_RELEASE, 4'h6, 9'd3);
    push_req(CMD_RELEASE, 4'hC, 9'd0);
    push_req(CMD_ALLOC, 4'd15, 9'h000);
    push_req(CMD_ALLOC, 4'd0, 9'h000);
    push_req(CMD_ALLOC, 4'd0, 9'h000);
    push_req(CMD_ALLOC, 4'd0, 9'h000);
    push_req(CMD_ALLOC, 4'd0, 9'h000);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait_drained();

    // use up every fresh id
    hot = KEY_W'($urandom);
    for (int i = 0; i < 300; i++) push_alloc();

    while (sent < ITEM_TARGET) begin
      wait_drained();
      busy_ids.delete();
      for (int i = 0; i < NUM_IDS; i++) begin
        if (id_busy[i]) busy_ids.push_back(8'(i));
      end
      calm    = (sent >= CALM_FROM);
      idle_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
      mode    = $urandom_range(0, 3);
      hot     = KEY_W'($urandom);
      n_batch = $urandom_range(20, 60);
      for (int k = 0; k < n_batch; k++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0: begin
            if (pick < 75) push_alloc(); else push_release();
          end
          1: begin
            if (pick < 25) push_alloc(); else push_release();
          end
          2: begin
            if (pick < 50) push_alloc(); else push_release();
          end
          default: begin
            push_req(CMD_W'($urandom), KEY_W'($urandom), REL_W'($urandom));
          end
        endcase
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
